### rtl/lkv_pkg.sv
// lkv_pkg: shared types and constants for the lru key-value cache
// no dependencies; imported by every rtl module of the block
package lkv_pkg;

	localparam int DEFAULT_ENTRIES = 16;
	localparam int KEY_W = 32;
	localparam int VAL_W = 31;
	localparam int CAP_W = 5;

	localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

	typedef enum logic {
		OP_GET = 1'b0,
		OP_PUT = 1'b1
	} lkv_op_t;

	// lookup outcome handed from the tag array to the top level
	typedef struct packed {
		logic             found;
		logic             get_hit;
		logic             value_wr;
		logic             evicted;
		logic [KEY_W-1:0] evicted_key;
	} lkv_lookup_t;

endpackage

### rtl/lkv_value_ram.sv
// lkv_value_ram: value storage, one write port and one registered read port
// depends on lkv_pkg for the value width
module lkv_value_ram
	import lkv_pkg::*;
#(
	parameter int ENTRIES = DEFAULT_ENTRIES,
	localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [IDX_W-1:0] wr_idx,
	input  logic [VAL_W-1:0] wr_data,
	input  logic             rd_en,
	input  logic [IDX_W-1:0] rd_idx,
	output logic [VAL_W-1:0] rd_data
);

	logic [VAL_W-1:0] mem [ENTRIES];
	logic [VAL_W-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_idx] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_idx];
		end
	end

	assign rd_data = rd_data_q;

endmodule

### rtl/lkv_tags.sv
// lkv_tags: key match array with valid bits, recency ranks and entry count
// depends on lkv_pkg for widths, op codes and the lookup struct
module lkv_tags
	import lkv_pkg::*;
#(
	parameter int ENTRIES = DEFAULT_ENTRIES,
	localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             go,
	input  lkv_op_t          op_s1,
	input  logic [KEY_W-1:0] key_s1,
	input  logic [CAP_W-1:0] cap,
	output lkv_lookup_t      lookup,
	output logic [IDX_W-1:0] hit_idx,
	output logic [IDX_W-1:0] wr_idx
);

	localparam int CNT_W = $clog2(ENTRIES + 1);
	localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

	logic [ENTRIES-1:0] valid_q;
	logic [KEY_W-1:0]   key_q [ENTRIES];
	logic [IDX_W-1:0]   rank_q [ENTRIES];
	logic [CNT_W-1:0]   count_q;

	logic [ENTRIES-1:0] hit_vec;
	logic [ENTRIES-1:0] lru_vec;
	logic               hit;
	logic [IDX_W-1:0]   hit_rank;
	logic [IDX_W-1:0]   lru_idx;
	logic [IDX_W-1:0]   free_idx;
	logic [IDX_W-1:0]   slot_idx;
	logic [IDX_W-1:0]   lru_rank;
	logic [CMP_W-1:0]   cap_ext;
	logic [CMP_W-1:0]   eff_cap;
	logic               full;
	logic               ins;
	logic               evict;

	assign cap_ext = CMP_W'(cap);
	assign eff_cap = (cap == '0) ? CMP_W'(1) :
		((cap_ext > CMP_W'(ENTRIES)) ? CMP_W'(ENTRIES) : cap_ext);
	assign full = CMP_W'(count_q) >= eff_cap;
	// ranks of valid entries are a permutation of 0..count-1
	assign lru_rank = IDX_W'(count_q - CNT_W'(1));

	always_comb begin
		hit_idx  = '0;
		hit_rank = '0;
		lru_idx  = '0;
		free_idx = '0;
		for (int i = 0; i < ENTRIES; i++) begin
			hit_vec[i] = valid_q[i] && (key_q[i] == key_s1);
			lru_vec[i] = valid_q[i] && (rank_q[i] == lru_rank);
		end
		for (int i = ENTRIES - 1; i >= 0; i--) begin
			if (hit_vec[i]) begin
				hit_idx  = IDX_W'(i);
				hit_rank = rank_q[i];
			end
			if (lru_vec[i]) begin
				lru_idx = IDX_W'(i);
			end
			if (!valid_q[i]) begin
				free_idx = IDX_W'(i);
			end
		end
	end

	assign hit      = |hit_vec;
	assign ins      = (op_s1 == OP_PUT) && !hit;
	assign evict    = ins && full;
	assign slot_idx = evict ? lru_idx : free_idx;
	assign wr_idx   = hit ? hit_idx : slot_idx;

	assign lookup.found       = hit;
	assign lookup.get_hit     = hit && (op_s1 == OP_GET);
	assign lookup.value_wr    = (op_s1 == OP_PUT);
	assign lookup.evicted     = evict;
	assign lookup.evicted_key = evict ? key_q[lru_idx] : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			count_q <= '0;
			for (int i = 0; i < ENTRIES; i++) begin
				rank_q[i] <= '0;
			end
		end else if (go) begin
			if (hit) begin
				for (int i = 0; i < ENTRIES; i++) begin
					if (IDX_W'(i) == hit_idx) begin
						rank_q[i] <= '0;
					end else if (valid_q[i] && (rank_q[i] < hit_rank)) begin
						rank_q[i] <= rank_q[i] + IDX_W'(1);
					end
				end
			end else if (ins) begin
				for (int i = 0; i < ENTRIES; i++) begin
					if (IDX_W'(i) == slot_idx) begin
						rank_q[i] <= '0;
					end else if (valid_q[i]) begin
						rank_q[i] <= rank_q[i] + IDX_W'(1);
					end
				end
				valid_q[slot_idx] <= 1'b1;
				if (!evict) begin
					count_q <= count_q + CNT_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go && ins) begin
			key_q[slot_idx] <= key_s1;
		end
	end

endmodule

### rtl/lru_key_value_cache_top.sv
// lru_key_value_cache_top: fully associative key-value cache, lru replacement
// depends on lkv_pkg, lkv_tags and lkv_value_ram
//
//   channel  direction  handshake             payload
//   in       in         in_valid / in_stall   op, key, value
//   out      out        out_valid / out_stall found, read_value, evicted, evicted_key
//   cfg      in         cfg_valid / cfg_ready cache_capacity
//
// one item per cycle unless the output stalls; an item goes from the input register to the result register
// the lookup, rank update and eviction choice sit between the input register
// and the result register, state is updated at the same edge the result loads
// reset clears valid bits, ranks, count and capacity (16); no clearing pass
// a stalled result holds the input register, which then stalls the input side
module lru_key_value_cache_top
	import lkv_pkg::*;
#(
	parameter int ENTRIES = DEFAULT_ENTRIES
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  logic             op,
	input  logic [KEY_W-1:0] key,
	input  logic [VAL_W-1:0] value,
	output logic             out_valid,
	input  logic             out_stall,
	output logic             found,
	output logic [VAL_W-1:0] read_value,
	output logic             evicted,
	output logic [KEY_W-1:0] evicted_key,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [CAP_W-1:0] cache_capacity
);

	localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

	logic             valid_s1;
	lkv_op_t          op_s1;
	logic [KEY_W-1:0] key_s1;
	logic [VAL_W-1:0] value_s1;

	logic             out_valid_q;
	logic             found_q;
	logic             get_hit_q;
	logic             evicted_q;
	logic [KEY_W-1:0] evicted_key_q;
	logic [CAP_W-1:0] cap_q;

	logic             out_free;
	logic             adv;
	lkv_lookup_t      lookup;
	logic [IDX_W-1:0] hit_idx;
	logic [IDX_W-1:0] wr_idx;
	logic [VAL_W-1:0] rd_data;

	assign out_free  = !out_valid_q || !out_stall;
	assign adv       = valid_s1 && out_free;
	assign in_stall  = valid_s1 && !out_free;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_RESET;
		end else if (cfg_valid && cfg_ready) begin
			cap_q <= cache_capacity;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			op_s1    <= lkv_op_t'(op);
			key_s1   <= key;
			value_s1 <= value;
		end
	end

	lkv_tags #(
		.ENTRIES(ENTRIES)
	) u_tags (
		.clk     (clk),
		.arst_n  (arst_n),
		.go      (adv),
		.op_s1   (op_s1),
		.key_s1  (key_s1),
		.cap     (cap_q),
		.lookup  (lookup),
		.hit_idx (hit_idx),
		.wr_idx  (wr_idx)
	);

	lkv_value_ram #(
		.ENTRIES(ENTRIES)
	) u_value_ram (
		.clk     (clk),
		.wr_en   (adv && lookup.value_wr),
		.wr_idx  (wr_idx),
		.wr_data (value_s1),
		.rd_en   (adv),
		.rd_idx  (hit_idx),
		.rd_data (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= adv;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			found_q       <= lookup.found;
			get_hit_q     <= lookup.get_hit;
			evicted_q     <= lookup.evicted;
			evicted_key_q <= lookup.evicted_key;
		end
	end

	assign out_valid   = out_valid_q;
	assign found       = found_q;
	assign read_value  = get_hit_q ? rd_data : '0;
	assign evicted     = evicted_q;
	assign evicted_key = evicted_key_q;

	// an eviction only follows a put miss
	a_evict_not_found: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && evicted) |-> !found)
		else $error("eviction reported together with a hit");

	// a returned value only comes from a hit
	a_value_needs_hit: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && get_hit_q) |-> found)
		else $error("value returned without a hit");

	// evicted key is zero unless an entry was evicted
	a_evict_key_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !evicted) |-> (evicted_key == '0))
		else $error("evicted key set without eviction");

	// a held result keeps the staged item in place
	a_stall_holds_s1: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |=> (valid_s1 && $stable(key_s1)))
		else $error("staged item lost under stall");

endmodule

### bench/lru_kv_checker.sv
// lru_kv_checker: watches the request, reply and capacity channels of the lru cache
// keeps its own copy of the cache contents, predicts every reply and compares them
// depends on lkv_pkg
module lru_kv_checker
	import lkv_pkg::*;
#(
	parameter int ENTRIES = DEFAULT_ENTRIES
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  logic             in_stall,
	input  logic             op,
	input  logic [KEY_W-1:0] key,
	input  logic [VAL_W-1:0] value,
	input  logic             out_valid,
	input  logic             out_stall,
	input  logic             found,
	input  logic [VAL_W-1:0] read_value,
	input  logic             evicted,
	input  logic [KEY_W-1:0] evicted_key,
	input  logic             cfg_valid,
	input  logic             cfg_ready,
	input  logic [CAP_W-1:0] cache_capacity,
	output int               mismatch_count,
	output int               pending_count
);

	typedef struct packed {
		logic             found;
		logic [VAL_W-1:0] read_value;
		logic             evicted;
		logic [KEY_W-1:0] evicted_key;
	} reply_t;

	bit               slot_used [ENTRIES];
	logic [KEY_W-1:0] slot_key  [ENTRIES];
	logic [VAL_W-1:0] slot_val  [ENTRIES];
	int               slot_age  [ENTRIES];
	int               used_count;
	logic [CAP_W-1:0] capacity;
	reply_t           replies[$];

	function automatic reply_t cache_access(input lkv_op_t req_op, input logic [KEY_W-1:0] req_key,
			input logic [VAL_W-1:0] req_val);
		reply_t r;
		int     hit;
		int     slot;
		int     limit;
		int     age;
		int     oldest;
		int     i;
		r = '0;
		hit = -1;
		slot = -1;
		for (i = 0; i < ENTRIES; i++) begin
			if (hit < 0 && slot_used[i] && slot_key[i] == req_key)
				hit = i;
		end
		if (hit >= 0) begin
			r.found = 1'b1;
			if (req_op == OP_GET)
				r.read_value = slot_val[hit];
			else
				slot_val[hit] = req_val;
			age = slot_age[hit];
			for (i = 0; i < ENTRIES; i++) begin
				if (slot_used[i] && slot_age[i] < age)
					slot_age[i]++;
			end
			slot_age[hit] = 0;
			return r;
		end
		if (req_op == OP_GET)
			return r;
		if (capacity == 0)
			limit = 1;
		else if (capacity > ENTRIES)
			limit = ENTRIES;
		else
			limit = capacity;
		if (used_count + 1 > limit) begin
			oldest = 0;
			for (i = 0; i < ENTRIES; i++) begin
				if (slot_used[i] && (slot < 0 || slot_age[i] >= oldest)) begin
					slot = i;
					oldest = slot_age[i];
				end
			end
			if (slot >= 0) begin
				r.evicted = 1'b1;
				r.evicted_key = slot_key[slot];
				slot_used[slot] = 1'b0;
				used_count--;
			end
		end
		if (slot < 0) begin
			for (i = 0; i < ENTRIES; i++) begin
				if (slot < 0 && !slot_used[i])
					slot = i;
			end
		end
		if (slot < 0)
			return r;
		for (i = 0; i < ENTRIES; i++) begin
			if (slot_used[i])
				slot_age[i]++;
		end
		slot_used[slot] = 1'b1;
		slot_key[slot] = req_key;
		slot_val[slot] = req_val;
		slot_age[slot] = 0;
		used_count++;
		return r;
	endfunction

	task automatic compare_field(input string name, input logic [KEY_W-1:0] want,
			input logic [KEY_W-1:0] got);
		if (got !== want) begin
			$display("%0t %s mismatch: expected %0h, actual %0h", $time, name, want, got);
			mismatch_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		reply_t want;
		int     i;
		if (!arst_n) begin
			for (i = 0; i < ENTRIES; i++) begin
				slot_used[i] = 1'b0;
				slot_key[i] = '0;
				slot_val[i] = '0;
				slot_age[i] = 0;
			end
			used_count = 0;
			capacity = CAP_RESET;
			replies.delete();
			mismatch_count = 0;
			pending_count <= 0;
		end else begin
			if (cfg_valid && cfg_ready)
				capacity = cache_capacity;
			if (in_valid && !in_stall)
				replies.push_back(cache_access(lkv_op_t'(op), key, value));
			if (out_valid && !out_stall) begin
				if (replies.size() == 0) begin
					$display("%0t reply transfer with no request pending: expected none, actual %0h",
						$time, {found, read_value, evicted, evicted_key});
					mismatch_count++;
				end else begin
					want = replies.pop_front();
					compare_field("found", KEY_W'(want.found), KEY_W'(found));
					compare_field("read_value", KEY_W'(want.read_value), KEY_W'(read_value));
					compare_field("evicted", KEY_W'(want.evicted), KEY_W'(evicted));
					compare_field("evicted_key", want.evicted_key, evicted_key);
				end
			end
			pending_count <= replies.size();
		end
	end

endmodule

### bench/tb_lru_key_value_cache_top.sv
// tb_lru_key_value_cache_top: drives get/put requests and capacity writes into the cache
// with random idling on both sides; the verdict comes from lru_kv_checker
// depends on lkv_pkg, lru_key_value_cache_top and lru_kv_checker
module tb_lru_key_value_cache_top;
	import lkv_pkg::*;

	localparam int CYCLE_LIMIT = 300000;
	localparam int PHASES = 12;
	localparam int PHASE_ITEMS = 140;
	localparam int POOL = 32;

	logic             clk;
	logic             arst_n;
	logic             in_valid;
	logic             in_stall;
	logic             op;
	logic [KEY_W-1:0] key;
	logic [VAL_W-1:0] value;
	logic             out_valid;
	logic             out_stall;
	logic             found;
	logic [VAL_W-1:0] read_value;
	logic             evicted;
	logic [KEY_W-1:0] evicted_key;
	logic             cfg_valid;
	logic             cfg_ready;
	logic [CAP_W-1:0] cache_capacity;

	int mismatch_count;
	int pending_count;
	int cycle_count;
	int gap_pct;
	int stall_pct;
	int stall_left;
	bit calm;

	logic [KEY_W-1:0] key_pool [POOL];

	lru_key_value_cache_top u_top (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.op             (op),
		.key            (key),
		.value          (value),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.found          (found),
		.read_value     (read_value),
		.evicted        (evicted),
		.evicted_key    (evicted_key),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cache_capacity (cache_capacity)
	);

	lru_kv_checker u_check (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.op             (op),
		.key            (key),
		.value          (value),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.found          (found),
		.read_value     (read_value),
		.evicted        (evicted),
		.evicted_key    (evicted_key),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cache_capacity (cache_capacity),
		.mismatch_count (mismatch_count),
		.pending_count  (pending_count)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("CHECK FAILED");
		$finish;
	end

	// reply side back-pressure in bursts
	initial begin
		out_stall <= 1'b0;
		stall_left = 0;
		forever begin
			@(posedge clk);
			if (calm) begin
				stall_left = 0;
				out_stall <= 1'b0;
			end else if (stall_left != 0) begin
				stall_left--;
				out_stall <= 1'b1;
			end else if (stall_pct != 0 && $urandom_range(99, 0) < stall_pct) begin
				stall_left = $urandom_range(15, 1) - 1;
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	task automatic send_request(input lkv_op_t req_op, input logic [KEY_W-1:0] req_key,
			input logic [VAL_W-1:0] req_val);
		int gap;
		gap = 0;
		if (!calm && gap_pct != 0 && $urandom_range(99, 0) < gap_pct)
			gap = $urandom_range(15, 1);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		op <= req_op;
		key <= req_key;
		value <= req_val;
		in_valid <= 1'b1;
		do @(posedge clk); while (in_stall);
	endtask

	task automatic wait_replies_done();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_count != 0) @(posedge clk);
	endtask

	task automatic write_capacity(input logic [CAP_W-1:0] cap);
		cache_capacity <= cap;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [KEY_W-1:0] pick_key(input int span);
		if ($urandom_range(99, 0) < 85)
			return key_pool[$urandom_range(span - 1, 0)];
		return $urandom;
	endfunction

	initial begin
		logic [CAP_W-1:0] cap_plan [9];
		logic [CAP_W-1:0] cap;
		int               span;
		int               put_pct;
		int               ph;
		int               n;
		cap_plan = '{5'd1, 5'd0, 5'd31, 5'd17, 5'd2, 5'd15, 5'd16, 5'd8, 5'd3};
		arst_n = 1'b0;
		in_valid <= 1'b0;
		op <= OP_GET;
		key <= '0;
		value <= '0;
		cfg_valid <= 1'b0;
		cache_capacity <= CAP_RESET;
		calm = 1'b0;
		gap_pct = 0;
		stall_pct = 20;
		key_pool[0] = '0;
		key_pool[1] = '1;
		for (n = 2; n < POOL; n++)
			key_pool[n] = $urandom;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty miss, field extremes, put hit, fill and evict at reset capacity
		send_request(OP_GET, 32'h0000_0000, 31'h0);
		send_request(OP_PUT, 32'h0000_0000, 31'h0);
		send_request(OP_PUT, 32'hFFFF_FFFF, 31'h7FFF_FFFF);
		send_request(OP_GET, 32'hFFFF_FFFF, 31'h0);
		send_request(OP_GET, 32'h0000_0000, 31'h7FFF_FFFF);
		send_request(OP_PUT, 32'h0000_0000, 31'h7FFF_FFFF);
		send_request(OP_GET, 32'h0000_0000, 31'h0);
		send_request(OP_GET, 32'h0001_2345, 31'h0);
		for (n = 1; n <= 14; n++)
			send_request(OP_PUT, KEY_W'(n), VAL_W'(n * 3));
		send_request(OP_PUT, 32'h8000_0000, 31'h0);
		// capacity lowered under the current count
		wait_replies_done();
		write_capacity(5'd2);
		send_request(OP_PUT, 32'h5555_5555, 31'h2AAA_AAAA);
		send_request(OP_GET, 32'h8000_0000, 31'h0);
		send_request(OP_PUT, 32'hAAAA_AAAA, 31'h5555_5555);

		for (ph = 0; ph < PHASES; ph++) begin
			wait_replies_done();
			cap = (ph < 9) ? cap_plan[ph] : CAP_W'($urandom_range(31, 0));
			write_capacity(cap);
			calm = (ph == PHASES - 1);
			case ($urandom_range(3, 0))
				0: gap_pct = 0;
				1: gap_pct = 5;
				2: gap_pct = 20;
				default: gap_pct = 40;
			endcase
			case ($urandom_range(3, 0))
				0: stall_pct = 0;
				1: stall_pct = 5;
				2: stall_pct = 20;
				default: stall_pct = 40;
			endcase
			span = (cap == 0) ? 1 : ((cap > DEFAULT_ENTRIES) ? DEFAULT_ENTRIES : int'(cap));
			span = span + $urandom_range(6, 0);
			if (span > POOL)
				span = POOL;
			put_pct = $urandom_range(75, 25);
			for (n = 0; n < PHASE_ITEMS; n++) begin
				send_request(($urandom_range(99, 0) < put_pct) ? OP_PUT : OP_GET,
					pick_key(span), VAL_W'($urandom));
			end
		end

		wait_replies_done();
		repeat (8) @(posedge clk);
		if (mismatch_count == 0 && pending_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
